>>> design/hmgfs_pkg.sv
`default_nettype none
package hmgfs_pkg;
    localparam int unsigned RsqrtStepsDefault = 3;
    localparam logic [63:0] SumMax = 64'd140737488355327;
    localparam logic [31:0] GravReset = 32'd16777216;

    typedef enum logic [2:0] {
        CFG_PLANET_X     = 3'd0,
        CFG_PLANET_Y     = 3'd1,
        CFG_ORBIT_RADIUS = 3'd2,
        CFG_HILL_SQ      = 3'd3,
        CFG_SMOOTH_SQ    = 3'd4,
        CFG_GRAV_CONST   = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_DIST, ST_NORM, ST_SEED,
        ST_NY2, ST_NT, ST_NY, ST_CY2, ST_CC, ST_GM, ST_GC,
        ST_PX, ST_PY, ST_ADDX, ST_ADDY, ST_OUT
    } t_state;

    function automatic logic [63:0] seed_lookup(input logic [3:0] idx);
        logic [63:0] v;
        case (idx)
            4'd5:  v = 64'd915690248;
            4'd6:  v = 64'd842312880;
            4'd7:  v = 64'd784150433;
            4'd8:  v = 64'd736580448;
            4'd9:  v = 64'd696736037;
            4'd10: v = 64'd662727413;
            4'd11: v = 64'd633258568;
            4'd12: v = 64'd607399643;
            4'd13: v = 64'd584470961;
            4'd14: v = 64'd563957123;
            4'd15: v = 64'd545461921;
            default: v = 64'd1012333456;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

>>> design/hmgfs_if.sv
`default_nettype none
interface hmgfs_cell_if;
    logic        valid;
    logic        ready;
    logic [31:0] cell_x;
    logic [31:0] cell_y;
    logic [31:0] cell_mass;
    logic [30:0] ring_radius;
    logic        last_cell;
    modport source(output valid, cell_x, cell_y, cell_mass, ring_radius, last_cell,
                   input ready);
    modport sink(input valid, cell_x, cell_y, cell_mass, ring_radius, last_cell,
                 output ready);
endinterface

interface hmgfs_force_if;
    logic        valid;
    logic        ready;
    logic [47:0] fx_inner_far;
    logic [47:0] fy_inner_far;
    logic [47:0] fx_inner_shell;
    logic [47:0] fy_inner_shell;
    logic [47:0] fx_outer_far;
    logic [47:0] fy_outer_far;
    logic [47:0] fx_outer_shell;
    logic [47:0] fy_outer_shell;
    logic        saturated;
    modport source(output valid, fx_inner_far, fy_inner_far, fx_inner_shell,
                   fy_inner_shell, fx_outer_far, fy_outer_far, fx_outer_shell,
                   fy_outer_shell, saturated, input ready);
    modport sink(input valid, fx_inner_far, fy_inner_far, fx_inner_shell,
                 fy_inner_shell, fx_outer_far, fy_outer_far, fx_outer_shell,
                 fy_outer_shell, saturated, output ready);
endinterface

interface hmgfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/hill_masked_gravity_force_sum.sv
`default_nettype none
// softened gravity sum of a polar grid's cells on one planet, with hill masking
// i_cell: one word per cell (position, mass, ring radius, last_cell flag)
// i_cfg: register writes, index 0..5, taken at any time, only while idle by contract
// o_force: one word with eight q16.32 sums and a saturation flag, sent after
//   the cell that carries last_cell; the sums are then cleared
// a cell runs through a sequencer around one shared 32x32 multiplier; each
//   64 bit product (low bits taken) is built from three partial products,
//   and the next cell is not taken until this one is done; a masked-out cell
//   leaves after ST_DIST, with no further products
// i_cell.ready is low while a cell is being worked on
// a last cell uses ST_OUT to load the force word into the output register;
//   while the receiver stalls it holds, and the next cell is not taken until
//   the word is gone
// reset (synchronous, active low) clears the sums, the flag and the registers
//   to their reset values (grav_const = 1.0)
module hill_masked_gravity_force_sum #(
    parameter int unsigned RSQRT_STEPS = hmgfs_pkg::RsqrtStepsDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hmgfs_cell_if.sink    i_cell,
    hmgfs_cfg_if.sink     i_cfg,
    hmgfs_force_if.source o_force
);
    import hmgfs_pkg::*;
    localparam int StepW = $clog2(RSQRT_STEPS + 1);

    t_state r_state, n_state;

    // configuration
    logic signed [31:0] r_px, r_py;
    logic [30:0] r_orbit;
    logic [63:0] r_hill, r_smooth;
    logic [31:0] r_grav;

    // per cell working registers
    logic signed [32:0] r_dx, r_dy;
    logic [31:0] r_mass;
    logic        r_inner, r_last;
    logic [63:0] r_a, r_b;       // temporaries
    logic [63:0] r_mq, r_y;
    logic [5:0]  r_q;
    logic [StepW-1:0] r_step;
    logic        r_shell;
    logic [63:0] r_gc;
    logic signed [47:0] r_tx, r_ty;

    logic signed [47:0] r_sum [8];
    logic r_sat;
    logic r_ovalid;

    // shared multiplier: low 64 bits of a 64x64 product in three passes
    // phase 0: lo*lo, phase 1: + hi*lo << 32, phase 2: + lo*hi << 32
    logic [63:0] mul_a, mul_b, mul_p;
    logic        mul_use;
    logic [1:0]  r_mph;
    logic [63:0] r_macc;
    logic [31:0] part_a, part_b;
    logic [63:0] part_p;
    logic        mul_last, step_go;

    always_comb begin
        case (r_mph)
            2'd1: begin part_a = mul_a[63:32]; part_b = mul_b[31:0];  end
            2'd2: begin part_a = mul_a[31:0];  part_b = mul_b[63:32]; end
            default: begin part_a = mul_a[31:0]; part_b = mul_b[31:0]; end
        endcase
    end
    assign part_p = 64'(part_a) * 64'(part_b);
    assign mul_p = (r_mph == 2'd0) ? part_p : r_macc + {part_p[31:0], 32'd0};
    assign mul_last = (r_mph == 2'd2);
    assign step_go = !mul_use || mul_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mph <= 2'd0;
            r_macc <= '0;
        end else if (mul_use) begin
            r_mph <= mul_last ? 2'd0 : r_mph + 2'd1;
            r_macc <= mul_p;
        end
    end

    logic [32:0] ux, uy;
    assign ux = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign uy = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);

    // d2 in r_a, after ST_DIST; s2 in r_b
    logic [64:0] d2_sum, s2_sum;
    assign d2_sum = {1'b0, r_a} + {1'b0, mul_p};
    assign s2_sum = {1'b0, r_a} + {1'b0, r_smooth};

    logic [63:0] quarter;
    assign quarter = (r_hill >> 2) + 64'(r_hill[1:0] != 2'b00);

    // normalise: leading bit position of s2
    logic [5:0] lead;
    always_comb begin
        lead = '0;
        for (int i = 0; i < 64; i++) begin
            if (r_b[i]) lead = 6'(i);
        end
    end
    logic [4:0] qn;
    assign qn = lead[5:1];
    logic [63:0] mq_n;
    always_comb begin
        if ({qn, 1'b0} >= 6'd30) mq_n = r_b >> ({qn, 1'b0} - 6'd30);
        else                     mq_n = r_b << (6'd30 - {qn, 1'b0});
    end

    logic [63:0] three_q30, h_n;
    assign three_q30 = 64'd3 << 30;
    assign h_n = (r_a > three_q30) ? 64'd0 : three_q30 - r_a;

    // term scaling: shift left by 56-3q
    logic signed [7:0] sh;
    assign sh = 8'sd56 - 8'(3 * r_q);
    function automatic logic [47:0] scale(input logic [63:0] p, input logic signed [7:0] s,
                                          output logic ovf);
        logic [63:0] m;
        m = '0;
        ovf = 1'b0;
        if (s >= 0) begin
            if (p > (SumMax >> s)) begin
                m = SumMax;
                ovf = 1'b1;
            end else begin
                m = p << s;
            end
        end else begin
            m = p >> (-s);
            if (m > SumMax) begin
                m = SumMax;
                ovf = 1'b1;
            end
        end
        return m[47:0];
    endfunction
    logic [47:0] scl;
    logic        scl_ovf;
    always_comb scl = scale(r_a, sh, scl_ovf);

    // accumulation, one axis per cycle
    logic [2:0]  acc_k;
    logic signed [47:0] acc_t;
    logic signed [48:0] acc_s;
    logic signed [47:0] acc_v;
    logic        acc_ovf;
    always_comb begin
        acc_k = {~r_inner, r_shell, r_state == ST_ADDY};
        acc_t = (r_state == ST_ADDY) ? r_ty : r_tx;
        acc_s = 49'(r_sum[acc_k]) + 49'(acc_t);
        acc_ovf = 1'b1;
        if (acc_s > 49'sd140737488355327)       acc_v = 48'sh7FFFFFFFFFFF;
        else if (acc_s < -49'sd140737488355328) acc_v = 48'sh800000000000;
        else begin
            acc_v = acc_s[47:0];
            acc_ovf = 1'b0;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_use = 1'b1;
        case (r_state)
            ST_SQX: begin mul_a = 64'(ux); mul_b = 64'(ux); end
            ST_SQY: begin mul_a = 64'(uy); mul_b = 64'(uy); end
            ST_NY2: begin mul_a = r_y;     mul_b = r_y;     end
            ST_NT:  begin mul_a = r_mq;    mul_b = r_a;     end
            ST_NY:  begin mul_a = r_y;     mul_b = h_n;     end
            ST_CY2: begin mul_a = r_y;     mul_b = r_y;     end
            ST_CC:  begin mul_a = r_a;     mul_b = r_y;     end
            ST_GM:  begin mul_a = 64'(r_grav); mul_b = 64'(r_mass); end
            ST_GC:  begin mul_a = r_a;     mul_b = r_b;     end
            ST_PX:  begin mul_a = 64'(ux); mul_b = r_gc;    end
            ST_PY:  begin mul_a = 64'(uy); mul_b = r_gc;    end
            default: mul_use = 1'b0;
        endcase
    end

    logic cell_take;
    assign cell_take = i_cell.valid && i_cell.ready;
    assign i_cell.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (cell_take) n_state = ST_SQX;
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_DIST;
            ST_DIST: begin
                if (r_a < quarter) n_state = r_last ? ST_OUT : ST_IDLE;
                else if (s2_sum[64] ? 1'b0 : (s2_sum[63:0] == 64'd0))
                    n_state = r_last ? ST_OUT : ST_IDLE;
                else n_state = ST_NORM;
            end
            ST_NORM: n_state = ST_SEED;
            ST_SEED: n_state = (RSQRT_STEPS == 0) ? ST_CY2 : ST_NY2;
            ST_NY2:  n_state = ST_NT;
            ST_NT:   n_state = ST_NY;
            ST_NY:   n_state = (32'(r_step) + 1 >= RSQRT_STEPS) ? ST_CY2 : ST_NY2;
            ST_CY2:  n_state = ST_CC;
            ST_CC:   n_state = ST_GM;
            ST_GM:   n_state = ST_GC;
            ST_GC:   n_state = ST_PX;
            ST_PX:   n_state = ST_PY;
            ST_PY:   n_state = ST_ADDX;
            ST_ADDX: n_state = ST_ADDY;
            ST_ADDY: n_state = r_last ? ST_OUT : ST_IDLE;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        // hold while the product is still being built
        if (!step_go) n_state = r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0; r_py <= '0; r_orbit <= '0;
            r_hill <= '0; r_smooth <= '0; r_grav <= GravReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_PLANET_X:     r_px <= i_cfg.data[31:0];
                CFG_PLANET_Y:     r_py <= i_cfg.data[31:0];
                CFG_ORBIT_RADIUS: r_orbit <= i_cfg.data[30:0];
                CFG_HILL_SQ:      r_hill <= i_cfg.data;
                CFG_SMOOTH_SQ:    r_smooth <= i_cfg.data;
                CFG_GRAV_CONST:   r_grav <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (step_go) begin
            case (r_state)
                ST_IDLE: if (cell_take) begin
                    r_dx <= 33'(signed'(i_cell.cell_x)) - 33'(r_px);
                    r_dy <= 33'(signed'(i_cell.cell_y)) - 33'(r_py);
                    r_mass  <= i_cell.cell_mass;
                    r_inner <= i_cell.ring_radius < r_orbit;
                    r_last  <= i_cell.last_cell;
                end
                ST_SQX:  r_a <= mul_p;
                ST_SQY:  begin
                    r_a <= d2_sum[64] ? '1 : d2_sum[63:0];
                end
                ST_DIST: begin
                    r_shell <= r_a < r_hill;
                    r_b <= s2_sum[64] ? '1 : s2_sum[63:0];
                end
                ST_NORM: begin
                    r_q  <= {1'b0, qn};
                    r_mq <= mq_n;
                end
                ST_SEED: begin
                    r_y <= seed_lookup(r_mq[31:28] < 4'd4 ? 4'd4 : r_mq[31:28]);
                    r_step <= '0;
                end
                ST_NY2:  r_a <= mul_p >> 30;
                ST_NT:   r_a <= mul_p >> 30;
                ST_NY:   begin
                    r_y <= mul_p >> 31;
                    r_step <= r_step + 1'b1;
                end
                ST_CY2:  r_a <= mul_p >> 30;
                ST_CC:   r_b <= mul_p >> 30;      // c
                ST_GM:   r_a <= mul_p >> 32;      // gm
                ST_GC:   r_gc <= mul_p >> 30;
                ST_PX:   r_a <= mul_p;
                ST_PY:   begin
                    r_tx <= r_dx[32] ? -signed'(scl) : signed'(scl);
                    r_a  <= mul_p;
                end
                ST_ADDX: r_ty <= r_dy[32] ? -signed'(scl) : signed'(scl);
                default: ;
            endcase
        end
    end

    // sums, flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_sum[k] <= '0;
            r_sat <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_force.valid && o_force.ready) r_ovalid <= 1'b0;
            if ((r_state == ST_PY || r_state == ST_ADDX) && scl_ovf) r_sat <= 1'b1;
            if (r_state == ST_ADDX || r_state == ST_ADDY) begin
                r_sum[acc_k] <= acc_v;
                if (acc_ovf) r_sat <= 1'b1;
            end
            if (r_state == ST_OUT) begin
                o_force.fx_inner_far   <= r_sum[0];
                o_force.fy_inner_far   <= r_sum[1];
                o_force.fx_inner_shell <= r_sum[2];
                o_force.fy_inner_shell <= r_sum[3];
                o_force.fx_outer_far   <= r_sum[4];
                o_force.fy_outer_far   <= r_sum[5];
                o_force.fx_outer_shell <= r_sum[6];
                o_force.fy_outer_shell <= r_sum[7];
                o_force.saturated      <= r_sat;
                for (int k = 0; k < 8; k++) r_sum[k] <= '0;
                r_sat <= 1'b0;
                r_ovalid <= 1'b1;
            end
        end
    end
    assign o_force.valid = r_ovalid;
endmodule
`default_nettype wire
